@@ rtl/stc_pkg.sv @@
`default_nettype none

package stc_pkg;

    // Sample format and channel layout.
    localparam int SAMPLE_BITS = 10;
    localparam int NUM_CH      = 8;
    localparam int NUM_BOARDS  = 4;
    localparam int BOARD_IDX_W = 2;

    // Calibration points are signed 16-bit values.
    localparam int CAL_W   = 16;
    localparam int SPAN_W  = CAL_W + 1;
    // Magnitude of sample * span, and the signed product.
    localparam int PROD_W  = SAMPLE_BITS + CAL_W;
    localparam int PRODS_W = PROD_W + 1;
    localparam int PROD_FULL_W = SAMPLE_BITS + 1 + SPAN_W;

    // Division by the ADC full scale as a reciprocal multiply plus one correction.
    localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned RECIP      = (64'd1 << PROD_W) / FULL_SCALE;
    localparam int RECIP_W = PROD_W - SAMPLE_BITS + 1;
    localparam int QUO_W   = CAL_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP[RECIP_W-1:0];
    localparam logic [PROD_W:0]    FS_WIDE = FULL_SCALE[PROD_W:0];

    // Board sums and their differences.
    localparam int SUM_W   = CAL_W + 1;
    localparam int MDIFF_W = SUM_W + 1;

    // Stream payload widths.
    localparam int IN_W  = ((NUM_CH * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W = 32;

    // Motor pulse widths in microseconds.
    localparam int PULSE_W = 11;
    localparam logic [PULSE_W-1:0] PULSE_STOP = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_RUN  = 11'd1500;

    // Configuration port.
    localparam int MARGIN_W   = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam logic [MARGIN_W-1:0] STOP_MARGIN_RST  = 8'd5;
    localparam logic [MARGIN_W-1:0] START_MARGIN_RST = 8'd30;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BOARD_CAL_0  = 3'd0,
        REG_BOARD_CAL_1  = 3'd1,
        REG_BOARD_CAL_2  = 3'd2,
        REG_BOARD_CAL_3  = 3'd3,
        REG_STOP_MARGIN  = 3'd4,
        REG_START_MARGIN = 3'd5
    } reg_idx_t;

    // Stage enables for the mapping lanes.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } lane_ctl_t;

    // Stage enables for the board selection and the motor update strobe.
    typedef struct packed {
        logic en4;
        logic en5;
        logic en6;
        logic upd;
    } sel_ctl_t;

    // One result beat.
    typedef struct packed {
        logic                   turn_right;
        logic [BOARD_IDX_W-1:0] brightest_board;
        logic                   right_running;
        logic                   left_running;
        logic [PULSE_W-1:0]     right_pulse_us;
        logic [PULSE_W-1:0]     left_pulse_us;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/stc_map_lane.sv @@
`default_nettype none

module stc_map_lane
    import stc_pkg::*;
(
    input  wire  logic                    clk,
    input  wire  lane_ctl_t               ctl,
    input  wire  logic [SAMPLE_BITS-1:0]  sample,
    input  wire  logic signed [CAL_W-1:0] cal_min,
    input  wire  logic signed [CAL_W-1:0] cal_max,
    output logic signed [CAL_W-1:0]       value
);

    // Stage 1: sample times calibration span.
    logic signed [SPAN_W-1:0]      span;
    logic signed [PROD_FULL_W-1:0] prod_full;
    logic signed [PRODS_W-1:0]     prod_next;
    logic signed [PRODS_W-1:0]     prod_reg;
    logic signed [CAL_W-1:0]       lo1_reg;

    assign span      = $signed({cal_max[CAL_W-1], cal_max}) - $signed({cal_min[CAL_W-1], cal_min});
    assign prod_full = $signed({1'b0, sample}) * span;
    assign prod_next = prod_full[PRODS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            prod_reg <= prod_next;
            lo1_reg  <= cal_min;
        end
    end

    // Stage 2: magnitude and reciprocal estimate of the quotient.
    logic                         neg_next;
    logic signed [PRODS_W-1:0]    mag_s;
    logic [PROD_W-1:0]            mag_next;
    logic [PROD_W+RECIP_W-1:0]    est_full;
    logic [QUO_W-1:0]             quo_next;
    logic                         neg_reg;
    logic [PROD_W-1:0]            mag_reg;
    logic [QUO_W-1:0]             quo_reg;
    logic signed [CAL_W-1:0]      lo2_reg;

    assign neg_next = prod_reg[PRODS_W-1];
    assign mag_s    = neg_next ? -prod_reg : prod_reg;
    assign mag_next = mag_s[PROD_W-1:0];
    assign est_full = mag_next * RECIP_V;
    assign quo_next = est_full[PROD_W +: QUO_W];

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            quo_reg <= quo_next;
            lo2_reg <= lo1_reg;
        end
    end

    // Stage 3: correct the estimate by one, restore the sign and add the offset.
    logic [QUO_W+SAMPLE_BITS-1:0] quo_fs;
    logic [PROD_W:0]              rem;
    logic [QUO_W-1:0]             quo_fix;
    logic signed [QUO_W:0]        quo_signed;
    logic signed [CAL_W+1:0]      val_full;
    logic signed [CAL_W-1:0]      value_next;
    logic signed [CAL_W-1:0]      value_reg;

    assign quo_fs     = {quo_reg, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, quo_reg};
    assign rem        = {1'b0, mag_reg} - quo_fs[PROD_W:0];
    assign quo_fix    = quo_reg + {{(QUO_W-1){1'b0}}, (rem >= FS_WIDE)};
    assign quo_signed = neg_reg ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});
    assign val_full   = $signed({{2{lo2_reg[CAL_W-1]}}, lo2_reg}) + quo_signed;
    assign value_next = val_full[CAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ rtl/stc_board_select.sv @@
`default_nettype none

module stc_board_select
    import stc_pkg::*;
(
    input  wire  logic                    clk,
    input  wire  logic                    rst_n,
    input  wire  sel_ctl_t                ctl,
    input  wire  logic signed [CAL_W-1:0] values [NUM_CH],
    input  wire  logic [MARGIN_W-1:0]     stop_margin,
    input  wire  logic [MARGIN_W-1:0]     start_margin,
    output result_t                       result
);

    // Stage 4: pair the lane values into board sums.
    logic signed [SUM_W-1:0] sum_reg [NUM_BOARDS];

    always_ff @(posedge clk)
    begin
        if (ctl.en4)
        begin
            for (int b = 0; b < NUM_BOARDS; b++)
            begin
                sum_reg[b] <= $signed({values[2*b][CAL_W-1], values[2*b]})
                            + $signed({values[2*b+1][CAL_W-1], values[2*b+1]});
            end
        end
    end

    // Stage 5: brightest board by truncated half sum, later board wins ties.
    logic signed [SUM_W-1:0]   adj  [NUM_BOARDS];
    logic signed [SUM_W-1:0]   half [NUM_BOARDS];
    logic signed [SUM_W-1:0]   best;
    logic [BOARD_IDX_W-1:0]    m_next;
    logic [BOARD_IDX_W-1:0]    li;
    logic [BOARD_IDX_W-1:0]    ri;
    logic                      right_next;
    logic signed [MDIFF_W-1:0] diff_next;
    logic [BOARD_IDX_W-1:0]    m_reg;
    logic                      right_reg;
    logic signed [MDIFF_W-1:0] diff_reg;

    always_comb
    begin
        for (int b = 0; b < NUM_BOARDS; b++)
        begin
            adj[b]  = $signed(sum_reg[b] + {{(SUM_W-1){1'b0}}, sum_reg[b][SUM_W-1]});
            half[b] = adj[b] >>> 1;
        end
        best   = half[0];
        m_next = '0;
        for (int b = 1; b < NUM_BOARDS; b++)
        begin
            if (half[b] >= best)
            begin
                best   = half[b];
                m_next = BOARD_IDX_W'(b);
            end
        end
    end

    assign li         = m_next - 2'd1;
    assign ri         = m_next + 2'd1;
    assign right_next = sum_reg[ri] >= sum_reg[li];
    assign diff_next  = $signed({sum_reg[m_next][SUM_W-1], sum_reg[m_next]})
                      - (right_next ? $signed({sum_reg[ri][SUM_W-1], sum_reg[ri]})
                                    : $signed({sum_reg[li][SUM_W-1], sum_reg[li]}));

    always_ff @(posedge clk)
    begin
        if (ctl.en5)
        begin
            m_reg     <= m_next;
            right_reg <= right_next;
            diff_reg  <= diff_next;
        end
    end

    // Stage 6: hysteresis on the chosen motor, the other one is forced off.
    logic signed [MDIFF_W-1:0] stop_lim;
    logic signed [MDIFF_W-1:0] start_lim;
    logic                      active_on;
    logic                      active_next;
    logic                      left_on_reg;
    logic                      right_on_reg;
    logic [BOARD_IDX_W-1:0]    m_out_reg;
    logic                      turn_out_reg;

    assign stop_lim  = $signed({{(MDIFF_W-MARGIN_W-1){1'b0}}, stop_margin, 1'b0});
    assign start_lim = $signed({{(MDIFF_W-MARGIN_W-1){1'b0}}, start_margin, 1'b0});
    assign active_on = right_reg ? right_on_reg : left_on_reg;

    always_comb
    begin
        if (active_on)
        begin
            active_next = !(diff_reg < stop_lim);
        end
        else
        begin
            active_next = diff_reg > start_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_on_reg  <= 1'b0;
            right_on_reg <= 1'b0;
        end
        else if (ctl.upd)
        begin
            left_on_reg  <= right_reg ? 1'b0 : active_next;
            right_on_reg <= right_reg ? active_next : 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en6)
        begin
            m_out_reg    <= m_reg;
            turn_out_reg <= right_reg;
        end
    end

    // Result beat.
    always_comb
    begin
        result.left_pulse_us   = left_on_reg ? PULSE_RUN : PULSE_STOP;
        result.right_pulse_us  = right_on_reg ? PULSE_RUN : PULSE_STOP;
        result.left_running    = left_on_reg;
        result.right_running   = right_on_reg;
        result.brightest_board = m_out_reg;
        result.turn_right      = turn_out_reg;
    end

endmodule

`default_nettype wire

@@ rtl/sun_tracking_motor_control_core.sv @@
// One item per cycle unless the output stalls; a stage takes a new beat when it is empty or when
// the stage after it moves, so bubbles close up while a stalled result beat waits at the output.
// Depth is three lane stages (multiply, reciprocal multiply, correction) plus board sums,
// board selection and the motor update.
// Reset (rst_n low, asynchronous) clears the stage valids and both motor flags and
// returns calibration to zero and the margins to 5 and 30.
`default_nettype none

module sun_tracking_motor_control_core
    import stc_pkg::*;
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    // Input stream
    input  wire  logic                  s_axis_tvalid,
    output logic                        s_axis_tready,
    // light_sample_0 .. light_sample_7, SAMPLE_BITS each, from bit 0 up
    input  wire  logic [IN_W-1:0]       s_axis_tdata,
    // Result stream
    output logic                        m_axis_tvalid,
    input  wire  logic                  m_axis_tready,
    // left_pulse_us[10:0], right_pulse_us[21:11], left_running[22], right_running[23],
    // brightest_board[25:24], turn_right[26], zeros above
    output logic [OUT_W-1:0]            m_axis_tdata,
    // Configuration port
    input  wire  logic                  psel,
    input  wire  logic                  penable,
    input  wire  logic                  pwrite,
    input  wire  logic [CFG_ADDR_W-1:0] paddr,
    input  wire  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int STAGES = 6;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] cal_reg [NUM_BOARDS];
    logic [MARGIN_W-1:0]   stop_reg;
    logic [MARGIN_W-1:0]   start_reg;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1 -: REG_IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOARDS; i++)
            begin
                cal_reg[i] <= '0;
            end
            stop_reg  <= STOP_MARGIN_RST;
            start_reg <= START_MARGIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BOARD_CAL_0:  cal_reg[0] <= pwdata;
                REG_BOARD_CAL_1:  cal_reg[1] <= pwdata;
                REG_BOARD_CAL_2:  cal_reg[2] <= pwdata;
                REG_BOARD_CAL_3:  cal_reg[3] <= pwdata;
                REG_STOP_MARGIN:  stop_reg   <= pwdata[MARGIN_W-1:0];
                REG_START_MARGIN: start_reg  <= pwdata[MARGIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (reg_idx)
            REG_BOARD_CAL_0:  prdata = cal_reg[0];
            REG_BOARD_CAL_1:  prdata = cal_reg[1];
            REG_BOARD_CAL_2:  prdata = cal_reg[2];
            REG_BOARD_CAL_3:  prdata = cal_reg[3];
            REG_STOP_MARGIN:  prdata = {{(CFG_DATA_W-MARGIN_W){1'b0}}, stop_reg};
            REG_START_MARGIN: prdata = {{(CFG_DATA_W-MARGIN_W){1'b0}}, start_reg};
            default:          prdata = '0;
        endcase
    end

    // Pipeline valids and per-stage enables; a stage moves when empty or when the next moves.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];

    // Mapping lanes, one per channel.
    lane_ctl_t               lane_ctl;
    logic signed [CAL_W-1:0] lane_value [NUM_CH];

    assign lane_ctl.en1 = stage_en[0];
    assign lane_ctl.en2 = stage_en[1];
    assign lane_ctl.en3 = stage_en[2];

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        localparam int SH = (c % 2) * 32;

        stc_map_lane u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .sample  (s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .cal_min ($signed(cal_reg[c/2][SH +: CAL_W])),
            .cal_max ($signed(cal_reg[c/2][SH+CAL_W +: CAL_W])),
            .value   (lane_value[c])
        );
    end

    // Board selection and motor update.
    sel_ctl_t sel_ctl;
    result_t  result;

    assign sel_ctl.en4 = stage_en[3];
    assign sel_ctl.en5 = stage_en[4];
    assign sel_ctl.en6 = stage_en[5];
    assign sel_ctl.upd = stage_en[5] && valid_reg[4];

    stc_board_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (sel_ctl),
        .values       (lane_value),
        .stop_margin  (stop_reg),
        .start_margin (start_reg),
        .result       (result)
    );

    assign m_axis_tdata = {{(OUT_W-$bits(result_t)){1'b0}}, result};

endmodule

`default_nettype wire

@@ rtl/stc_checker.sv @@
`default_nettype none

module stc_checker
    import stc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tready,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // With the result register empty, the pipeline behind it can always take a beat.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output side empty");

    // Only the motor on the chosen side may run.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[26] ? !m_axis_tdata[22] : !m_axis_tdata[23]))
        else $error("motor on the wrong side is running");

    // Pulse widths follow the running flags.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[10:0] == (m_axis_tdata[22] ? PULSE_RUN : PULSE_STOP)) &&
            (m_axis_tdata[21:11] == (m_axis_tdata[23] ? PULSE_RUN : PULSE_STOP)))
        else $error("pulse width does not match motor flag");

endmodule

bind sun_tracking_motor_control_core stc_checker u_stc_checker (.*);

`default_nettype wire
